FILE: rtl/yac_pkg.sv
// ----------------------------------------------------------------------------
// yac_pkg: shared types, constants and helpers of the YUV alpha crossfade.
// Holds the fixed-point color coefficients and the small arithmetic helpers
// used by the pipeline stages.
// ----------------------------------------------------------------------------
package yac_pkg;

  localparam int PixW  = 8;
  localparam int InW   = 6 * PixW;
  localparam int OutW  = 3 * PixW;
  localparam int CoefW = 17;
  localparam int TermW = 9;
  localparam int SumW  = 11;

  typedef logic [PixW-1:0]         pix_t;
  typedef logic [CoefW-1:0]        coef_t;
  typedef logic [TermW-1:0]        term_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // Coefficients are round(c * 65536).
  localparam coef_t K_RV = 17'd91881;
  localparam coef_t K_GU = 17'd22553;
  localparam coef_t K_GV = 17'd46802;
  localparam coef_t K_BU = 17'd116130;
  localparam coef_t K_YR = 17'd19595;
  localparam coef_t K_YG = 17'd38470;
  localparam coef_t K_YB = 17'd7471;
  localparam coef_t K_UR = 17'd11056;
  localparam coef_t K_UG = 17'd21712;
  localparam coef_t K_UB = 17'd32768;
  localparam coef_t K_VR = 17'd32768;
  localparam coef_t K_VG = 17'd27440;
  localparam coef_t K_VB = 17'd5328;

  localparam pix_t  ChromaOfs = 8'd128;
  localparam sum_t  PixMax    = 11'sd255;

  // Truncated magnitude product: floor(coef * mag / 65536).
  function automatic term_t qterm(input coef_t coef, input pix_t mag);
    logic [CoefW+PixW-1:0] p;
    p = {{PixW{1'b0}}, coef} * {{CoefW{1'b0}}, mag};
    return p[CoefW+PixW-1 -: TermW];
  endfunction

  // Applies a sign to a truncated magnitude.
  function automatic sum_t sterm(input term_t t, input logic neg);
    sum_t s;
    s = sum_t'({{(SumW-TermW){1'b0}}, t});
    return neg ? -s : s;
  endfunction

  // Saturates a signed sum to the pixel range.
  function automatic pix_t clamp8(input sum_t v);
    pix_t r;
    if (v[SumW-1]) begin
      r = '0;
    end else if (v > PixMax) begin
      r = '1;
    end else begin
      r = v[PixW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/yuv_alpha_crossfade.sv
// ----------------------------------------------------------------------------
// yuv_alpha_crossfade: alpha blend of two YUV pixel streams.
// Converts two full-range BT.601 YUV pixels to RGB, blends them with a
// programmable weight and converts the blend back to YUV.
//
// One pixel pair enters per clock and the blended pixel comes out of the
// five-stage pipeline (chroma multiply, RGB sum and clamp, blend,
// RGB-to-YUV multiply, YUV sum and clamp), which it passes in that order;
// the throughput stays at one item per cycle as long as the output side takes
// items. Each stage has its own valid bit and moves whenever the stage after
// it is empty or moving, so bubbles collapse and the input keeps being taken
// while a finished item waits at the output, until no stage is empty. The
// weight alpha is written through the cfg port (always ready) and should
// only change while the pipeline is empty; it resets to 255, which gives the
// first image 255/256 of the weight.
// ----------------------------------------------------------------------------
module yuv_alpha_crossfade (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // luma_a, cb_a, cr_a, luma_b, cb_b, cr_b, from bit 0 up
  input  logic [yac_pkg::InW-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // luma_out, cb_out, cr_out, from bit 0 up
  output logic [yac_pkg::OutW-1:0] m_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [yac_pkg::PixW-1:0] cfg_data
);
  import yac_pkg::*;

  localparam int NStg = 5;

  // Stage 1: luma plus signed-magnitude chroma products of one pixel.
  typedef struct packed {
    pix_t  y;
    logic  u_neg;
    logic  v_neg;
    term_t t_rv;
    term_t t_gu;
    term_t t_gv;
    term_t t_bu;
  } chroma_t;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

  typedef struct packed {
    term_t yr, yg, yb;
    term_t ur, ug, ub;
    term_t vr, vg, vb;
  } yuv_terms_t;

  logic [NStg:1] vld;
  logic [NStg:1] adv;

  pix_t       alpha;
  chroma_t    s1_a, s1_b;
  rgb_t       s2_a, s2_b;
  rgb_t       s3_m;
  yuv_terms_t s4_t;
  pix_t       luma_out, cb_out, cr_out;

  // Unpacked input fields.
  pix_t luma_a, cb_a, cr_a, luma_b, cb_b, cr_b;
  assign luma_a = s_tdata[0*PixW +: PixW];
  assign cb_a   = s_tdata[1*PixW +: PixW];
  assign cr_a   = s_tdata[2*PixW +: PixW];
  assign luma_b = s_tdata[3*PixW +: PixW];
  assign cb_b   = s_tdata[4*PixW +: PixW];
  assign cr_b   = s_tdata[5*PixW +: PixW];

  // ---------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or its successor
  // advances. The last stage is the output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    adv[NStg] = ~vld[NStg] | m_tready;
    for (int k = NStg - 1; k >= 1; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  assign s_tready = adv[1];
  assign m_tvalid = vld[NStg];
  assign m_tdata  = {cr_out, cb_out, luma_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= NStg; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Configuration: the blend weight register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 8'd255;
    end else if (cfg_valid) begin
      alpha <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: split chroma into sign and magnitude around 128 and form the
  // truncated coefficient products, so truncation runs toward zero.
  // ---------------------------------------------------------------------------
  function automatic chroma_t chroma_mul(input pix_t y, input pix_t cb, input pix_t cr);
    chroma_t c;
    pix_t    u_mag, v_mag;
    u_mag     = cb[PixW-1] ? {1'b0, cb[PixW-2:0]} : ChromaOfs - cb;
    v_mag     = cr[PixW-1] ? {1'b0, cr[PixW-2:0]} : ChromaOfs - cr;
    c.y       = y;
    c.u_neg   = ~cb[PixW-1];
    c.v_neg   = ~cr[PixW-1];
    c.t_rv    = qterm(K_RV, v_mag);
    c.t_gu    = qterm(K_GU, u_mag);
    c.t_gv    = qterm(K_GV, v_mag);
    c.t_bu    = qterm(K_BU, u_mag);
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_a <= chroma_mul(luma_a, cb_a, cr_a);
      s1_b <= chroma_mul(luma_b, cb_b, cr_b);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: signed sums and clamp to RGB.
  // ---------------------------------------------------------------------------
  function automatic rgb_t to_rgb(input chroma_t c);
    rgb_t r;
    sum_t y;
    y   = sum_t'({{(SumW-PixW){1'b0}}, c.y});
    r.r = clamp8(y + sterm(c.t_rv, c.v_neg));
    r.g = clamp8(y - sterm(c.t_gu, c.u_neg) - sterm(c.t_gv, c.v_neg));
    r.b = clamp8(y + sterm(c.t_bu, c.u_neg));
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_a <= to_rgb(s1_a);
      s2_b <= to_rgb(s1_b);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-channel blend. The two weights add up to 256, so the sum
  // never exceeds 16 bits and the shift by 8 rounds down.
  // ---------------------------------------------------------------------------
  logic [PixW:0] alpha_inv;
  assign alpha_inv = 9'd256 - {1'b0, alpha};

  function automatic pix_t mix(input pix_t p, input pix_t q, input pix_t a,
                               input logic [PixW:0] ai);
    logic [2*PixW:0] s;
    s = {{(PixW+1){1'b0}}, p} * {{(PixW+1){1'b0}}, a}
      + {{(PixW+1){1'b0}}, q} * {{PixW{1'b0}}, ai};
    return s[2*PixW-1:PixW];
  endfunction

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_m.r <= mix(s2_a.r, s2_b.r, alpha, alpha_inv);
      s3_m.g <= mix(s2_a.g, s2_b.g, alpha, alpha_inv);
      s3_m.b <= mix(s2_a.b, s2_b.b, alpha, alpha_inv);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: RGB-to-YUV products; the blend is never negative, so every
  // term is a plain truncated magnitude.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_t.yr <= qterm(K_YR, s3_m.r);
      s4_t.yg <= qterm(K_YG, s3_m.g);
      s4_t.yb <= qterm(K_YB, s3_m.b);
      s4_t.ur <= qterm(K_UR, s3_m.r);
      s4_t.ug <= qterm(K_UG, s3_m.g);
      s4_t.ub <= qterm(K_UB, s3_m.b);
      s4_t.vr <= qterm(K_VR, s3_m.r);
      s4_t.vg <= qterm(K_VG, s3_m.g);
      s4_t.vb <= qterm(K_VB, s3_m.b);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sums with the chroma offset, clamp, and the output register.
  // ---------------------------------------------------------------------------
  sum_t ofs;
  assign ofs = sum_t'({{(SumW-PixW){1'b0}}, ChromaOfs});

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      luma_out <= clamp8(sterm(s4_t.yr, 1'b0) + sterm(s4_t.yg, 1'b0)
                         + sterm(s4_t.yb, 1'b0));
      cb_out   <= clamp8(ofs - sterm(s4_t.ur, 1'b0) - sterm(s4_t.ug, 1'b0)
                         + sterm(s4_t.ub, 1'b0));
      cr_out   <= clamp8(ofs + sterm(s4_t.vr, 1'b0) - sterm(s4_t.vg, 1'b0)
                         - sterm(s4_t.vb, 1'b0));
    end
  end

endmodule

FILE: rtl/yac_checker.sv
// ----------------------------------------------------------------------------
// yac_checker: port-level checks for the YUV alpha crossfade.
// Watches the stream handshakes and the pipeline latency.
// ----------------------------------------------------------------------------
module yac_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [yac_pkg::OutW-1:0] m_tdata
);

  // A stalled output item keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // With room at the output, the input side is never stalled.
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled although the output can move");

  // An accepted item reaches the output after passing every stage when the output takes items meanwhile.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
      |=> m_tvalid)
    else $error("item missing at the output after the pipeline latency");

endmodule

bind yuv_alpha_crossfade yac_checker u_yac_checker (.*);
